[src/lmfs_pkg.sv]
// Package for the LED matrix flash scanner: command codes, queue entry and
// status structs, register indexes and reset constants. No dependencies.
package lmfs_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;

   localparam logic [7:0] TEST_TICKS_RESET = 8'd10;
   localparam logic [2:0] FLASH_BIT_RESET  = 3'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_TEST_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FLASH_BIT  = 2'd1;

   typedef enum logic [2:0] {
      CMD_SET_LED     = 3'd0,
      CMD_REFRESH     = 3'd1,
      CMD_SLOW        = 3'd2,
      CMD_SHOW_SINGLE = 3'd3,
      CMD_SET_ENABLE  = 3'd4
   } cmd_type;

   // One decoded command as it waits in the queue.
   typedef struct packed {
      cmd_type    kind;
      logic [1:0] row;
      logic [3:0] bit_sel;
      logic [1:0] state;
      logic       enable;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic pop;
      logic refresh;
   } back_status_type;

endpackage

[src/lmfs_front.sv]
// Front end of the LED matrix flash scanner: takes request beats, decodes
// the command and pushes known commands into the queue. Uses lmfs_pkg.
module lmfs_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lmfs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [2:0]                        req_tuser,
   input  lmfs_pkg::queue_status_type        q_status,
   output logic                              push,
   output lmfs_pkg::op_type                  push_op
);
   import lmfs_pkg::*;

   logic known;

   assign req_tready = !q_status.full;

   always_comb begin
      unique case (req_tuser) inside
         CMD_SET_LED, CMD_REFRESH, CMD_SLOW, CMD_SHOW_SINGLE, CMD_SET_ENABLE: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   // LED index bits 5:4 name the row, bits 3:0 the column within the row.
   always_comb begin
      push_op.kind    = cmd_type'(req_tuser);
      push_op.row     = req_tdata[5:4];
      push_op.bit_sel = req_tdata[3:0];
      push_op.state   = req_tdata[7:6];
      push_op.enable  = req_tdata[8];
   end

   // Unused command codes are taken and dropped here.
   assign push = req_tvalid && req_tready && known;

endmodule

[src/lmfs_queue.sv]
// Short FIFO between the front and back of the LED matrix flash scanner.
// Holds decoded commands. Uses lmfs_pkg.
module lmfs_queue #(
   parameter int Depth = lmfs_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lmfs_pkg::op_type            push_op,
   input  logic                        pop,
   output lmfs_pkg::op_type            head_op,
   output lmfs_pkg::queue_status_type  status
);
   import lmfs_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   op_type          entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == FullCnt);
   assign status.empty = (count_ff == '0);
   assign head_op      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[src/lmfs_back.sv]
// Back end of the LED matrix flash scanner: executes queued commands on the
// display planes, counters and registers, and drives the response register.
// Uses lmfs_pkg.
module lmfs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  lmfs_pkg::op_type                  head_op,
   input  lmfs_pkg::queue_status_type        q_status,
   output lmfs_pkg::back_status_type         b_status,
   input  logic                              csr_we,
   input  logic [lmfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lmfs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lmfs_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import lmfs_pkg::*;

   // Plane 0 is shown while the flash bit is 0, plane 1 while it is 1.
   logic [15:0] plane_ff [2][4];
   logic [15:0] plane_in [2][4];
   logic [1:0]  scan_row_ff, scan_row_in;
   logic [7:0]  flash_ff, flash_in;
   logic [7:0]  countdown_ff, countdown_in;
   logic        drive_ff, drive_in;
   logic [2:0]  phase_ff, phase_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] word_ff, word_in;
   logic [1:0]  row_ff;
   logic        drv_ff;
   logic        can_load;
   logic        pop;
   logic        is_refresh;
   logic [1:0]  row_next;
   logic        plane_sel;

   assign can_load   = !rsp_valid_ff || rsp_tready;
   assign pop        = !q_status.empty && can_load;
   assign is_refresh = (head_op.kind == CMD_REFRESH);
   assign row_next   = scan_row_ff + 2'd1;
   assign plane_sel  = flash_ff[phase_ff];

   assign b_status.pop     = pop;
   assign b_status.refresh = pop && is_refresh;

   always_comb begin
      plane_in     = plane_ff;
      scan_row_in  = scan_row_ff;
      flash_in     = flash_ff;
      countdown_in = countdown_ff;
      drive_in     = drive_ff;
      phase_in     = phase_ff;
      word_in      = (countdown_ff != 8'd0) ? 16'hFFFF : plane_ff[plane_sel][row_next];

      if (pop) begin
         unique case (head_op.kind)
            CMD_SET_LED: begin
               plane_in[0][head_op.row][head_op.bit_sel] = head_op.state[1];
               plane_in[1][head_op.row][head_op.bit_sel] = head_op.state[0];
            end
            CMD_REFRESH: begin
               scan_row_in = row_next;
            end
            CMD_SLOW: begin
               flash_in = flash_ff + 8'd1;
               if (countdown_ff != 8'd0) begin
                  countdown_in = countdown_ff - 8'd1;
               end
            end
            CMD_SHOW_SINGLE: begin
               for (int p = 0; p < 2; p++) begin
                  for (int r = 0; r < 4; r++) begin
                     plane_in[p][r] = '0;
                  end
               end
               plane_in[0][head_op.row][head_op.bit_sel] = 1'b1;
               plane_in[1][head_op.row][head_op.bit_sel] = 1'b1;
            end
            CMD_SET_ENABLE: begin
               drive_in = head_op.enable;
            end
            default: begin
            end
         endcase
      end

      // The user must make writes only while the block is idle; the block itself
      // does not enforce this. A new test length restarts the all-on test.
      if (csr_we) begin
         unique case (csr_index)
            REG_TEST_TICKS: begin
               countdown_in = csr_wdata;
            end
            REG_FLASH_BIT: begin
               phase_in = csr_wdata[2:0];
            end
            default: begin
            end
         endcase
      end

      if (pop && is_refresh) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < 2; p++) begin
            for (int r = 0; r < 4; r++) begin
               plane_ff[p][r] <= '0;
            end
         end
         scan_row_ff  <= '0;
         flash_ff     <= '0;
         countdown_ff <= TEST_TICKS_RESET;
         drive_ff     <= 1'b1;
         phase_ff     <= FLASH_BIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         plane_ff     <= plane_in;
         scan_row_ff  <= scan_row_in;
         flash_ff     <= flash_in;
         countdown_ff <= countdown_in;
         drive_ff     <= drive_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && is_refresh) begin
         word_ff <= word_in;
         row_ff  <= row_next;
         drv_ff  <= drive_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, drv_ff, row_ff, word_ff};

endmodule

[src/led_matrix_flash_scanner_top.sv]
// Top level of the LED matrix flash scanner: ties front end, command queue
// and back end together. Uses lmfs_pkg, lmfs_front, lmfs_queue, lmfs_back.
//
// Commands arrive as request beats: req_tuser carries the command code
// (set LED, refresh tick, slow tick, show single, set enable), req_tdata the
// LED index, LED state and enable value. Only a refresh tick produces a
// response beat, which carries the 16-bit column word for the row now being
// driven, the row number and the row drive enable. Every other command
// updates state and returns nothing. A refresh tick is written into the queue,
// executed from the queue head, and its response is registered in the
// response register that drives rsp_tvalid. The front takes one beat per
// cycle while the queue is not full; the back end executes one command per
// cycle from the queue head while the response register is not stalled.
// When the receiver stalls, the response register holds its beat and the
// back end stops; the queue absorbs up to QueueDepth further beats before
// req_tready drops. Reset (synchronous, active high) clears the planes and
// counters, sets drive enable and restarts the all-on start-up test of ten
// slow ticks. The csr port may be written only while the block is idle;
// writing the test length restarts the test.
module led_matrix_flash_scanner_top #(
   parameter int QueueDepth = lmfs_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata, from bit 0: led_index[5:0], led_state[7:6], enable_value[8],
   // zero fill above.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lmfs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: command[2:0].
   input  logic [2:0]                        req_tuser,
   // rsp_tdata, from bit 0: column_word[15:0], row_select[17:16],
   // row_drive_on[18], zero fill above.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lmfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [lmfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lmfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lmfs_pkg::*;

   queue_status_type q_status;
   back_status_type  b_status;
   op_type           push_op;
   op_type           head_op;
   logic             push;

   lmfs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .push_op    (push_op)
   );

   lmfs_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (b_status.pop),
      .head_op (head_op),
      .status  (q_status)
   );

   lmfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_op    (head_op),
      .q_status   (q_status),
      .b_status   (b_status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The queue is never full and empty at once.
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty together");

   // The back end only pops from a non-empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      b_status.pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // An executed refresh tick shows up as a response beat next cycle.
   a_refresh_resp: assert property (@(posedge clock) disable iff (reset)
      b_status.refresh |=> rsp_tvalid)
      else $error("refresh executed without response");

   // Nothing is executed while a response beat is stalled.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !b_status.pop)
      else $error("command executed while response stalled");

endmodule
